### rtl/core/first_fit_partition_allocator_macros.svh
// Assertion macros for the first-fit partition allocator.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FFPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffpa assertion failed");

// Next-cycle implication, checked out of reset.
`define FFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffpa assertion failed");

`endif

### rtl/core/ffpa_pkg.sv
// Package: codes, field widths and defaults of the first-fit partition allocator.
package ffpa_pkg;

    localparam int PARTITIONS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 16;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int OWNER_W  = 16;
    localparam int LEFT_W   = 16;
    localparam int TOTAL_W  = 20;

    localparam logic [TOTAL_W-1:0] SUM_MAX = 20'hFFFFF;
    localparam logic [OWNER_W-1:0] REQ_MAX = 16'hFFFF;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_CLEAR = 2'd0;
    localparam t_action ACT_ADD   = 2'd1;
    localparam t_action ACT_ALLOC = 2'd2;
    localparam t_action ACT_QUERY = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NOFIT = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

### rtl/core/first_fit_partition_allocator.sv
// First-fit fixed-partition allocator: top level with partition table memory and scan sequencer.
//
// Usage: drive i_action, i_size and i_partition_index with start high; the
// request is taken at the clock edge where start is high and busy is low.
// Exactly one result follows per request, shown for a single cycle with
// o_done high; the receiver cannot hold it off, so it must sample it then.
// Steps from request edge to o_done:
//   clear, add, table full, index out of range, allocate on empty table: none
//   query of a valid index: one synchronous read of the table
//   allocate: one table read, then a step for each partition passed over
//   before a grant; the scan reads one table entry per cycle through the
//   single read port.
// busy is high from the accepting edge until the result edge, so a new
// request can be taken in the cycle o_done is shown.
// Reset empties the table and zeroes the request counter and both totals;
// the partition memory needs no clearing, as entries at or past the fill
// count are never read and an add rewrites the whole entry.
module first_fit_partition_allocator #(
    parameter int PARTITIONS = ffpa_pkg::PARTITIONS_DEF,
    parameter int SIZE_BITS  = ffpa_pkg::SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ffpa_pkg::ACTION_W-1:0] i_action,
    input  logic [ffpa_pkg::SIZE_W-1:0]   i_size,
    input  logic [ffpa_pkg::INDEX_W-1:0]  i_partition_index,
    output logic                          o_done,
    output logic [ffpa_pkg::STATUS_W-1:0] o_status,
    output logic [ffpa_pkg::INDEX_W-1:0]  o_partition_index_res,
    output logic [ffpa_pkg::OWNER_W-1:0]  o_owner,
    output logic [ffpa_pkg::LEFT_W-1:0]   o_leftover,
    output logic [ffpa_pkg::TOTAL_W-1:0]  o_internal_total,
    output logic [ffpa_pkg::TOTAL_W-1:0]  o_external_total
);
    import ffpa_pkg::*;
    `include "first_fit_partition_allocator_macros.svh"

    localparam int AW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CW = $clog2(PARTITIONS + 1);
    localparam int SW = SIZE_BITS + CW;
    localparam int QW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_QUERY = 2'd2;

    typedef struct packed {
        logic                 used;
        logic [SIZE_BITS-1:0] size;
        logic [OWNER_W-1:0]   owner;
        logic [SIZE_BITS-1:0] leftover;
    } t_entry;

    t_entry mem [PARTITIONS];
    t_entry r_rd;
    t_entry wr_data;
    logic   mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [OWNER_W-1:0]   r_req, n_req;
    logic [SW-1:0]        r_int, n_int;
    logic [SW-1:0]        r_ext, n_ext;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [SIZE_BITS-1:0] r_sz, n_sz;
    logic [INDEX_W-1:0]   r_qidx, n_qidx;

    logic                 r_done, n_done;
    t_status              r_status, n_status;
    logic [INDEX_W-1:0]   r_idx, n_idx;
    logic [OWNER_W-1:0]   r_own, n_own;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic [TOTAL_W-1:0]   r_tint, r_text;
    logic [TOTAL_W-1:0]   sat_int, sat_ext;

    logic [SIZE_BITS-1:0] req_size;
    logic [SIZE_BITS-1:0] fit_left;
    logic [CW-1:0]        ptr_inc;
    logic                 fit;
    logic                 accept;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign req_size = SIZE_BITS'(i_size);
    assign fit      = !r_rd.used && (r_rd.size != '0) && (r_rd.size >= r_sz);
    assign fit_left = r_rd.size - r_sz;
    assign ptr_inc  = CW'(r_ptr) + CW'(1);

    always_comb begin
        if ({{TOTAL_W{1'b0}}, n_int} > {{SW{1'b0}}, SUM_MAX}) begin
            sat_int = SUM_MAX;
        end else begin
            sat_int = TOTAL_W'(n_int);
        end
        if ({{TOTAL_W{1'b0}}, n_ext} > {{SW{1'b0}}, SUM_MAX}) begin
            sat_ext = SUM_MAX;
        end else begin
            sat_ext = TOTAL_W'(n_ext);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_req    = r_req;
        n_int    = r_int;
        n_ext    = r_ext;
        n_ptr    = r_ptr;
        n_sz     = r_sz;
        n_qidx   = r_qidx;
        n_done   = 1'b0;
        n_status = r_status;
        n_idx    = r_idx;
        n_own    = r_own;
        n_left   = r_left;
        mem_we   = 1'b0;
        wr_addr  = r_ptr;
        wr_data  = r_rd;
        rd_addr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx  = '0;
                    n_own  = '0;
                    n_left = '0;
                    unique case (i_action)
                        ACT_CLEAR: begin
                            n_count  = '0;
                            n_req    = '0;
                            n_int    = '0;
                            n_ext    = '0;
                            n_done   = 1'b1;
                            n_status = ST_OK;
                        end
                        ACT_ADD: begin
                            n_done = 1'b1;
                            if (r_count == CW'(PARTITIONS)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status         = ST_OK;
                                n_idx            = INDEX_W'(r_count);
                                mem_we           = 1'b1;
                                wr_addr          = AW'(r_count);
                                wr_data.used     = 1'b0;
                                wr_data.size     = req_size;
                                wr_data.owner    = '0;
                                wr_data.leftover = '0;
                                n_count          = r_count + CW'(1);
                                n_ext            = r_ext + SW'(req_size);
                            end
                        end
                        ACT_ALLOC: begin
                            n_req = (r_req == REQ_MAX) ? r_req : r_req + OWNER_W'(1);
                            n_sz  = req_size;
                            n_ptr = '0;
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_NOFIT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_QUERY: begin
                            n_qidx = i_partition_index;
                            if (QW'(i_partition_index) >= QW'(r_count)) begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                                n_idx    = i_partition_index;
                            end else begin
                                rd_addr = AW'(i_partition_index);
                                n_state = S_QUERY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (fit) begin
                    mem_we           = 1'b1;
                    wr_addr          = r_ptr;
                    wr_data.used     = 1'b1;
                    wr_data.owner    = r_req;
                    wr_data.leftover = fit_left;
                    n_int            = r_int + SW'(fit_left);
                    n_ext            = r_ext - SW'(r_rd.size);
                    n_done           = 1'b1;
                    n_status         = ST_OK;
                    n_idx            = INDEX_W'(r_ptr);
                    n_own            = r_req;
                    n_left           = LEFT_W'(fit_left);
                    n_state          = S_IDLE;
                end else if (ptr_inc == r_count) begin
                    n_done   = 1'b1;
                    n_status = ST_NOFIT;
                    n_idx    = '0;
                    n_own    = '0;
                    n_left   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_ptr   = AW'(ptr_inc);
                    rd_addr = AW'(ptr_inc);
                end
            end
            S_QUERY: begin
                n_done   = 1'b1;
                n_status = ST_OK;
                n_idx    = r_qidx;
                n_own    = r_rd.owner;
                n_left   = LEFT_W'(r_rd.leftover);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // partition table, one read and one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_req   <= '0;
            r_int   <= '0;
            r_ext   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_req   <= n_req;
            r_int   <= n_int;
            r_ext   <= n_ext;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_sz     <= n_sz;
        r_qidx   <= n_qidx;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_own    <= n_own;
        r_left   <= n_left;
        if (n_done) begin
            r_tint <= sat_int;
            r_text <= sat_ext;
        end
    end

    assign o_done                = r_done;
    assign o_status              = r_status;
    assign o_partition_index_res = r_idx;
    assign o_owner               = r_own;
    assign o_leftover            = r_left;
    assign o_internal_total      = r_tint;
    assign o_external_total      = r_text;

    `FFPA_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    `FFPA_ASSERT_NEXT(a_fast_done, i_clk, i_rst_n, accept && (i_action == ACT_CLEAR || i_action == ACT_ADD), r_done)
    `FFPA_ASSERT_IMP(a_full_count, i_clk, i_rst_n, r_done && (r_status == ST_FULL), r_count == CW'(PARTITIONS))
    `FFPA_ASSERT_IMP(a_scan_ptr, i_clk, i_rst_n, r_state == S_SCAN, CW'(r_ptr) < r_count)

endmodule

### verif/tb_first_fit_partition_allocator.sv
// Testbench for first_fit_partition_allocator: random and directed requests with a predictor.
`timescale 1ns / 100ps

module tb_first_fit_partition_allocator;
    import ffpa_pkg::*;

    localparam int NPART       = PARTITIONS_DEF;
    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int RANDOM_REQS = 610;

    typedef struct packed {
        t_status               status;
        logic [INDEX_W-1:0]    index;
        logic [OWNER_W-1:0]    owner;
        logic [LEFT_W-1:0]     leftover;
        logic [TOTAL_W-1:0]    in_total;
        logic [TOTAL_W-1:0]    ex_total;
    } t_reply;

    class partition_table_check;
        logic [SIZE_W-1:0]  size_tab [NPART];
        bit                 used_tab [NPART];
        logic [OWNER_W-1:0] owner_tab [NPART];
        logic [LEFT_W-1:0]  left_tab [NPART];
        int unsigned        fill;
        logic [OWNER_W-1:0] req_num;
        logic [TOTAL_W-1:0] in_sum;
        logic [TOTAL_W-1:0] ex_sum;
        t_reply             expected_replies[$];
        int unsigned        mismatches;

        function new();
            foreach (size_tab[k]) size_tab[k] = '0;
            wipe_table();
            mismatches = 0;
        endfunction

        function void wipe_table();
            foreach (used_tab[k]) begin
                used_tab[k]  = 1'b0;
                owner_tab[k] = '0;
                left_tab[k]  = '0;
            end
            fill    = 0;
            req_num = '0;
            in_sum  = '0;
            ex_sum  = '0;
        endfunction

        function void refresh_totals();
            int unsigned in_acc;
            int unsigned ex_acc;
            in_acc = 0;
            ex_acc = 0;
            for (int k = 0; k < fill; k++) begin
                if (used_tab[k]) in_acc += left_tab[k];
                else ex_acc += size_tab[k];
            end
            in_sum = (in_acc > SUM_MAX) ? SUM_MAX : TOTAL_W'(in_acc);
            ex_sum = (ex_acc > SUM_MAX) ? SUM_MAX : TOTAL_W'(ex_acc);
        endfunction

        function int unsigned pending();
            return expected_replies.size();
        endfunction

        function void take_request(t_action act, logic [SIZE_W-1:0] sz,
                                   logic [INDEX_W-1:0] qidx);
            t_reply r;
            r = '0;
            case (act)
                ACT_CLEAR: begin
                    wipe_table();
                end
                ACT_ADD: begin
                    if (fill >= NPART) begin
                        r.status = ST_FULL;
                    end else begin
                        r.index         = INDEX_W'(fill);
                        size_tab[fill]  = sz;
                        used_tab[fill]  = 1'b0;
                        owner_tab[fill] = '0;
                        left_tab[fill]  = '0;
                        fill++;
                        refresh_totals();
                    end
                end
                ACT_ALLOC: begin
                    if (req_num != REQ_MAX) req_num++;
                    r.status = ST_NOFIT;
                    for (int k = 0; k < fill; k++) begin
                        if (!used_tab[k] && size_tab[k] != 0 && size_tab[k] >= sz) begin
                            used_tab[k]  = 1'b1;
                            owner_tab[k] = req_num;
                            left_tab[k]  = size_tab[k] - sz;
                            r.status     = ST_OK;
                            r.index      = INDEX_W'(k);
                            r.owner      = req_num;
                            r.leftover   = left_tab[k];
                            break;
                        end
                    end
                    refresh_totals();
                end
                default: begin
                    r.index = qidx;
                    if (qidx >= fill) begin
                        r.status = ST_RANGE;
                    end else if (used_tab[qidx]) begin
                        r.owner    = owner_tab[qidx];
                        r.leftover = left_tab[qidx];
                    end
                end
            endcase
            r.in_total = in_sum;
            r.ex_total = ex_sum;
            expected_replies.push_back(r);
        endfunction

        function void diff(string field, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void match_result(t_reply got);
            t_reply want;
            if (expected_replies.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            diff("status", TOTAL_W'(want.status), TOTAL_W'(got.status));
            diff("partition_index_res", TOTAL_W'(want.index), TOTAL_W'(got.index));
            diff("owner", TOTAL_W'(want.owner), TOTAL_W'(got.owner));
            diff("leftover", TOTAL_W'(want.leftover), TOTAL_W'(got.leftover));
            diff("internal_total", want.in_total, got.in_total);
            diff("external_total", want.ex_total, got.ex_total);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_action              i_action = ACT_CLEAR;
    logic [SIZE_W-1:0]    i_size = '0;
    logic [INDEX_W-1:0]   i_partition_index = '0;
    logic                 o_done;
    t_status              o_status;
    logic [INDEX_W-1:0]   o_partition_index_res;
    logic [OWNER_W-1:0]   o_owner;
    logic [LEFT_W-1:0]    o_leftover;
    logic [TOTAL_W-1:0]   o_internal_total;
    logic [TOTAL_W-1:0]   o_external_total;

    partition_table_check sb = new();
    int unsigned          cycles = 0;
    int unsigned          sent = 0;

    first_fit_partition_allocator dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_action              (i_action),
        .i_size                (i_size),
        .i_partition_index     (i_partition_index),
        .o_done                (o_done),
        .o_status              (o_status),
        .o_partition_index_res (o_partition_index_res),
        .o_owner               (o_owner),
        .o_leftover            (o_leftover),
        .o_internal_total      (o_internal_total),
        .o_external_total      (o_external_total)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.match_result('{o_status, o_partition_index_res, o_owner, o_leftover,
                              o_internal_total, o_external_total});
        end
    end

    task automatic pause();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 45) n = 0;
        else if (r < 88) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send(t_action act, logic [SIZE_W-1:0] sz, logic [INDEX_W-1:0] qidx,
                        bit idle = 1'b1);
        start             <= 1'b1;
        i_action          <= act;
        i_size            <= sz;
        i_partition_index <= qidx;
        do @(posedge i_clk); while (busy);
        sb.take_request(act, sz, qidx);
        sent++;
        if (idle) pause();
    endtask

    // hold off until every outstanding request has been answered
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return SIZE_W'($urandom_range(0, 1));
            1, 2:    return SIZE_W'($urandom_range(1, 15));
            3, 4, 5: return SIZE_W'($urandom_range(16, 4095));
            default: return SIZE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_request_size();
        logic [SIZE_W-1:0] s;
        int unsigned d;
        int q;
        q = $urandom_range(0, 9);
        if (q == 0) return '0;
        if (q <= 4 && sb.fill > 0) begin
            s = sb.size_tab[$urandom_range(0, sb.fill - 1)];
            d = $urandom_range(0, 2);
            return (s > d) ? s - SIZE_W'(d) : '0;
        end
        return pick_size();
    endfunction

    function automatic logic [INDEX_W-1:0] pick_query_index();
        if ($urandom_range(0, 9) < 7)
            return INDEX_W'($urandom_range(0, (sb.fill > 15) ? 15 : sb.fill));
        return INDEX_W'($urandom);
    endfunction

    task automatic directed_phase();
        send(ACT_CLEAR, 16'hFFFF, 4'hF);
        send(ACT_QUERY, '0, 4'd0);
        send(ACT_ALLOC, 16'd5, '0);
        send(ACT_ADD, 16'd0, '0);
        send(ACT_ADD, 16'hFFFF, '0);
        send(ACT_ADD, 16'd100, '0);
        send(ACT_ALLOC, 16'd0, '0);
        send(ACT_ALLOC, 16'd60, '0);
        send(ACT_ALLOC, 16'hFFFF, '0);
        send(ACT_QUERY, '0, 4'd0);
        send(ACT_QUERY, '0, 4'd1);
        send(ACT_QUERY, '0, 4'd2);
        send(ACT_QUERY, '0, 4'hF);
        drain();
        for (int k = 3; k < NPART; k++)
            send(ACT_ADD, SIZE_W'(1 << (k - 3)), '0);
        send(ACT_ADD, 16'd1, '0);
        send(ACT_ALLOC, 16'h8000, '0);
    endtask

    task automatic random_phase();
        int unsigned stop_at;
        int n_add;
        int n_ops;
        int r;
        stop_at = sent + RANDOM_REQS;
        while (sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send(t_action'($urandom_range(0, 3)), SIZE_W'($urandom), INDEX_W'($urandom));
            end else begin
                send(ACT_CLEAR, SIZE_W'($urandom), INDEX_W'($urandom));
                n_add = (r < 30) ? $urandom_range(14, 18) : $urandom_range(1, 10);
                for (int k = 0; k < n_add; k++)
                    send(ACT_ADD, pick_size(), INDEX_W'($urandom));
                n_ops = $urandom_range(4, 20);
                for (int k = 0; k < n_ops; k++) begin
                    case ($urandom_range(0, 19))
                        0, 1:    send(ACT_ADD, pick_size(), INDEX_W'($urandom));
                        2, 3, 4, 5, 6, 7:
                                 send(ACT_QUERY, SIZE_W'($urandom), pick_query_index());
                        default: send(ACT_ALLOC, pick_request_size(), INDEX_W'($urandom));
                    endcase
                end
                if ($urandom_range(0, 9) == 0) drain();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_phase();
        random_phase();
        drain();
        repeat (NPART + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
